[rtl/ksc_pkg.sv]
// Shared types and constants of the keyed substitution cipher.
package ksc_pkg;

  localparam int BYTE_W    = 8;
  localparam int KEY_LEN_W = 9;
  localparam int FUNC_W    = 2;

  // Substitution table geometry.
  localparam int TABLE_SIZE = 254;
  localparam int TBL_AW     = 8;
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TABLE_SIZE - 1);

  // Item functions.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_TABLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_KEY   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENCRYPT    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DECRYPT    = 2'd3;

  // Result status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // Register index decoded from the word address.
  localparam logic REG_KEY_LENGTH = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic key_cap;    // password byte is on the key memory output
    logic step;       // advance the table search by one entry
    logic res_enc;    // table output is the cipher byte
    logic res_found;  // search hit: form the plain byte
    logic res_miss;   // search ran off the table end
    logic out_load;   // move the result into the output register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_load;    // the offered input beat is a load item
    logic is_enc;     // the item in work is an encrypt
    logic hit;        // table entry on the memory output matches
    logic last;       // the entry examined is the last of the table
    logic out_busy;   // output register holds a beat that is not taken
  } sts_t;

endpackage

[rtl/ksc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ksc_ctrl.sv]
// Controller state machine that sequences load, encrypt and decrypt items.
module ksc_ctrl import ksc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  sts_t  sts,
  output ctrl_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_KEY    = 3'd1;
  localparam logic [2:0] S_ENC    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = sts.in_load ? S_FINISH : S_KEY;
        end
      end
      S_KEY: begin
        cmd.key_cap = 1'b1;
        state_nxt   = sts.is_enc ? S_ENC : S_SEARCH;
      end
      S_ENC: begin
        cmd.res_enc = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_SEARCH: begin
        if (sts.hit) begin
          cmd.res_found = 1'b1;
          state_nxt     = S_FINISH;
        end else if (sts.last) begin
          cmd.res_miss = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a beat that was not taken");

  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.last)
    else $error("table search stepped past the last entry");

  a_cipher_goes_to_key: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !sts.in_load) |=> (state_r == S_KEY))
    else $error("cipher item did not fetch its password byte");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.res_enc, cmd.res_found, cmd.res_miss, cmd.accept}))
    else $error("more than one result source in one cycle");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

[rtl/ksc_datapath.sv]
// Datapath: table and password memories, key position, search index and result registers.
module ksc_datapath import ksc_pkg::*; #(
  parameter int MAX_KEY_LEN = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                cmd,
  output sts_t                 sts,
  input  logic [15:0]          in_tdata,
  input  logic [2:0]           in_tuser,
  input  logic [KEY_LEN_W-1:0] key_length,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [BYTE_W-1:0]    out_tdata,
  output logic                 out_tuser
);

  localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_LEN);
  localparam logic [KEY_LEN_W-1:0] TSIZE9  = KEY_LEN_W'(TABLE_SIZE);

  logic [FUNC_W-1:0] in_func;
  logic [BYTE_W-1:0] in_slot;
  logic [BYTE_W-1:0] in_data;
  logic              in_first;

  assign in_slot  = in_tdata[7:0];
  assign in_data  = in_tdata[15:8];
  assign in_func  = in_tuser[1:0];
  assign in_first = in_tuser[2];

  logic [KAW-1:0]    key_pos_r;
  logic              is_enc_r;
  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] key_r;
  logic [TBL_AW-1:0] idx_r;
  logic [BYTE_W-1:0] res_byte_r;
  logic              res_stat_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_stat_r;

  // Effective password length: zero acts as one, large values saturate.
  logic [KEY_LEN_W-1:0] eff_len;
  always_comb begin
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  // Position used by the offered item, and the position after it.
  logic [KAW-1:0] cur_pos;
  logic [KAW:0]   pos_p1;
  logic [KAW-1:0] pos_nxt;
  always_comb begin
    if (in_first || (KEY_LEN_W'(key_pos_r) >= eff_len)) begin
      cur_pos = '0;
    end else begin
      cur_pos = key_pos_r;
    end
    pos_p1 = {1'b0, cur_pos} + (KAW + 1)'(1);
    if (KEY_LEN_W'(pos_p1) >= eff_len) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_p1[KAW-1:0];
    end
  end

  logic in_load;
  assign in_load = (in_func == FUNC_LOAD_TABLE) || (in_func == FUNC_LOAD_KEY);

  // Memory write enables; out-of-range slots write nothing.
  logic tbl_we;
  logic key_we;
  assign tbl_we = cmd.accept && (in_func == FUNC_LOAD_TABLE)
                  && (KEY_LEN_W'(in_slot) < TSIZE9);
  assign key_we = cmd.accept && (in_func == FUNC_LOAD_KEY)
                  && (KEY_LEN_W'(in_slot) < MAX_LEN);

  logic [BYTE_W-1:0] key_rdata;
  logic [BYTE_W-1:0] tbl_rdata;
  logic [TBL_AW-1:0] tbl_raddr;

  ksc_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_LEN)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_slot[KAW-1:0]),
    .wdata (in_data),
    .raddr (cur_pos),
    .rdata (key_rdata)
  );

  ksc_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_slot),
    .wdata (in_data),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Password byte and data byte reduced mod 254, then the encrypt index.
  logic [BYTE_W-1:0]    key_mod;
  logic [BYTE_W-1:0]    data_mod;
  logic [KEY_LEN_W-1:0] enc_sum;
  logic [TBL_AW-1:0]    enc_idx;
  always_comb begin
    key_mod  = (key_rdata >= BYTE_W'(TABLE_SIZE)) ? key_rdata - BYTE_W'(TABLE_SIZE)
                                                   : key_rdata;
    data_mod = (data_r >= BYTE_W'(TABLE_SIZE)) ? data_r - BYTE_W'(TABLE_SIZE) : data_r;
    enc_sum  = KEY_LEN_W'(data_mod) + KEY_LEN_W'(key_mod);
    if (enc_sum >= TSIZE9) begin
      enc_idx = TBL_AW'(enc_sum - TSIZE9);
    end else begin
      enc_idx = TBL_AW'(enc_sum);
    end
  end

  always_comb begin
    if (cmd.key_cap) begin
      tbl_raddr = is_enc_r ? enc_idx : '0;
    end else if (idx_r == TBL_LAST) begin
      tbl_raddr = idx_r;
    end else begin
      tbl_raddr = idx_r + TBL_AW'(1);
    end
  end

  // Plain byte from the matching index: (index - key) mod 254.
  logic [KEY_LEN_W-1:0] dec_val;
  always_comb begin
    if (idx_r >= key_r) begin
      dec_val = KEY_LEN_W'(idx_r) - KEY_LEN_W'(key_r);
    end else begin
      dec_val = KEY_LEN_W'(idx_r) + TSIZE9 - KEY_LEN_W'(key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_enc_r <= (in_func == FUNC_ENCRYPT);
      data_r   <= in_data;
      if (in_load) begin
        res_byte_r <= '0;
        res_stat_r <= STATUS_OK;
      end
    end
    if (cmd.key_cap) begin
      key_r <= key_mod;
      idx_r <= '0;
    end
    if (cmd.step) begin
      idx_r <= idx_r + TBL_AW'(1);
    end
    if (cmd.res_enc) begin
      res_byte_r <= tbl_rdata;
      res_stat_r <= STATUS_OK;
    end
    if (cmd.res_found) begin
      res_byte_r <= dec_val[BYTE_W-1:0];
      res_stat_r <= STATUS_OK;
    end
    if (cmd.res_miss) begin
      res_byte_r <= '0;
      res_stat_r <= STATUS_NOT_FOUND;
    end
    if (cmd.out_load) begin
      out_byte_r <= res_byte_r;
      out_stat_r <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        key_pos_r <= in_load ? '0 : pos_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_load  = in_load;
  assign sts.is_enc   = is_enc_r;
  assign sts.hit      = (tbl_rdata == data_r);
  assign sts.last     = (idx_r == TBL_LAST);
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_stat_r;

endmodule

[rtl/keyed_substitution_cipher_top.sv]
// Top level of the keyed substitution cipher: channels, register port, controller and datapath.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------------------
//   in_     | slave     | in_tvalid/in_tready   | tdata: slot, data_byte; tuser: func, first
//   out_    | master    | out_tvalid/out_tready | tdata: out_byte; tuser: status
//   cfg_    | APB slave | psel/penable/pready   | key_length at byte address 0
//
// A load item goes from the idle state straight to the finish state; an encrypt item
// first reads its password byte and then the table. A decrypt item reads its password
// byte and then searches the table, one entry per cycle through the table memory's read
// port, examining up to 254 entries. The finish state moves the result into the output
// register; the next beat is accepted while that result still waits.
// Reset (synchronous, active low) clears the controller, the password position, the
// output valid flag and sets key_length to 1; the memories are not cleared. An output
// stall holds a finished item until the output register frees up.
module keyed_substitution_cipher_top import ksc_pkg::*; #(
  parameter int MAX_KEY_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] slot, [15:8] data_byte
  input  logic [2:0]  in_tuser,   // [1:0] func, [2] first
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] status
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // The single register, key_length, sits at word index 0; the byte offset bits are
  // ignored and a write to word index 1 lands nowhere.
  logic [KEY_LEN_W-1:0] key_length_r;
  logic                 cfg_wr;
  logic                 cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_KEY_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_W'(1);
    end else if (cfg_wr && cfg_hit) begin
      key_length_r <= cfg_pwdata[KEY_LEN_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? 32'(key_length_r) : '0;

  // The controller sees in_tvalid and the status from the datapath, and drives in_tready and commands back.
  ctrl_t cmd;
  sts_t  sts;

  ksc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ksc_datapath #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .key_length (key_length_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench of the keyed substitution cipher: stream stimulus, prediction, checks.
import ksc_pkg::*;

localparam int KEY_SLOTS = 256;

// One result beat: the cipher or plain byte and its status flag.
typedef struct packed {
  logic [BYTE_W-1:0] text_byte;
  logic              status;
} cipher_beat_t;

// Keeps its own copy of the table, the password, the position and key_length,
// predicts the result of every accepted beat and compares the results in order.
class cipher_checker;
  logic [BYTE_W-1:0]    sub_table [TABLE_SIZE];
  logic [BYTE_W-1:0]    password [KEY_SLOTS];
  int unsigned          position;
  logic [KEY_LEN_W-1:0] key_length;
  cipher_beat_t         expected_beats [$];
  int                   errors, beats_in, beats_out, loads, encrypts, decrypts, misses;

  function new();
    position   = 0;
    key_length = 1;
    errors     = 0;
    beats_in   = 0;
    beats_out  = 0;
    loads      = 0;
    encrypts   = 0;
    decrypts   = 0;
    misses     = 0;
  endfunction

  task report(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Zero behaves as one and anything past the password store as its full size.
  function int unsigned period();
    if (key_length == 0) return 1;
    if (key_length > KEY_SLOTS) return KEY_SLOTS;
    return key_length;
  endfunction

  task take_item(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] slot,
                 input logic [BYTE_W-1:0] data, input logic first,
                 output logic [BYTE_W-1:0] predicted);
    int unsigned  len, pos, key, hit;
    bit           found;
    cipher_beat_t beat;
    beat.text_byte = '0;
    beat.status    = STATUS_OK;
    beats_in++;
    if (func == FUNC_LOAD_TABLE || func == FUNC_LOAD_KEY) begin
      // Out-of-range slots write nothing, yet every load restarts the password.
      if (func == FUNC_LOAD_TABLE && slot < TABLE_SIZE) sub_table[slot] = data;
      if (func == FUNC_LOAD_KEY && slot < KEY_SLOTS) password[slot] = data;
      position = 0;
      loads++;
    end else begin
      len = period();
      pos = (first || position >= len) ? 0 : position;
      key = password[pos] % TABLE_SIZE;
      if (func == FUNC_ENCRYPT) begin
        beat.text_byte = sub_table[(data + key) % TABLE_SIZE];
        encrypts++;
      end else begin
        found = 1'b0;
        hit   = 0;
        for (int j = 0; j < TABLE_SIZE && !found; j++) begin
          if (sub_table[j] == data) begin
            found = 1'b1;
            hit   = j;
          end
        end
        if (found) begin
          beat.text_byte = BYTE_W'((hit + TABLE_SIZE - key) % TABLE_SIZE);
        end else begin
          beat.status = STATUS_NOT_FOUND;
          misses++;
        end
        decrypts++;
      end
      pos = pos + 1;
      if (pos >= len) pos = 0;
      position = pos;
    end
    predicted = beat.text_byte;
    expected_beats.push_back(beat);
  endtask

  task match_result(input logic [BYTE_W-1:0] got_byte, input logic got_status);
    cipher_beat_t want;
    beats_out++;
    if (expected_beats.size() == 0) begin
      report($sformatf("result byte %02h status %0b with nothing expected", got_byte, got_status));
    end else begin
      want = expected_beats.pop_front();
      if (got_byte !== want.text_byte)
        report($sformatf("result %0d: byte %02h, expected %02h", beats_out, got_byte,
                         want.text_byte));
      if (got_status !== want.status)
        report($sformatf("result %0d: status %0b, expected %0b", beats_out, got_status,
                         want.status));
    end
  endtask
endclass

module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [7:0] slot, [15:8] data_byte
  logic [2:0]  in_tuser = '0;    // [1:0] func, [2] first

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] out_byte
  logic        out_tuser;        // [0] status

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Idle rates of the two sides in percent per cycle, changed between phases.
  int send_idle_pct = 23;
  int recv_idle_pct = 61;
  int key_settings = 0;

  cipher_checker chk;

  keyed_substitution_cipher_top #(.MAX_KEY_LEN(KEY_SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // The receiver stalls at random, one fresh decision per cycle, so stalls land
  // on every phase of the block's work including the long decrypt searches.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Everything is sampled right at the edge, before any of this step's updates
  // land, so a beat is seen exactly as the block saw it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.match_result(out_tdata, out_tuser);
  end

  // Safety net against a hung handshake; far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("timeout: %0d results still expected", chk.expected_beats.size());
    $display("testbench: FAIL");
    $finish;
  end

  // Offers one beat after a random gap and holds it until the block takes it.
  // Valid is not dropped here, so back-to-back beats need no dead cycle.
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [7:0] slot,
                           input logic [7:0] data, input logic first,
                           output logic [7:0] predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {data, slot};
    in_tuser  <= {first, func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chk.take_item(func, slot, data, first, predicted);
  endtask

  // The sender holds off until every expected result has come back. Every beat
  // produces a result, so an empty queue means the block is idle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (chk.expected_beats.size() != 0) @(posedge clk);
  endtask

  // Writes key_length with a setup and an access phase, then reads it back the same way.
  task automatic set_key_length(input logic [KEY_LEN_W-1:0] len);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_KEY_LENGTH, 2'b00};
    cfg_pwdata  <= 32'(len);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    chk.key_length = len;
    key_settings++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== 32'(len))
      chk.report($sformatf("key_length reads %0h, written %0h", cfg_prdata, len));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    // Mostly recoverable bytes, now and then the two that wrap past the table.
    if ($urandom_range(9) == 0) return 8'(254 + $urandom_range(1));
    return 8'($urandom_range(253));
  endfunction

  // Mostly encrypt-then-decrypt messages with random content, so the decrypt
  // search runs on real cipher bytes; the rest is loads, broken messages and noise.
  task automatic random_block(input int count);
    int         sent, mlen, pick;
    logic [7:0] cipher [$];
    logic [7:0] pb;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        mlen = $urandom_range(1, 12);
        cipher.delete();
        for (int k = 0; k < mlen; k++) begin
          send_item(FUNC_ENCRYPT, 8'($urandom), plain_byte(), k == 0, pb);
          cipher.push_back(pb);
        end
        for (int k = 0; k < mlen; k++)
          send_item(FUNC_DECRYPT, 8'($urandom), cipher[k], k == 0, pb);
        sent += 2 * mlen;
      end else if (pick < 75) begin
        if ($urandom_range(1) == 0)
          send_item(FUNC_LOAD_TABLE, 8'($urandom), 8'($urandom), 1'($urandom), pb);
        else
          send_item(FUNC_LOAD_KEY, 8'($urandom), 8'($urandom), 1'($urandom), pb);
        sent++;
      end else if (pick < 85) begin
        // A message that carries on from wherever the position stands.
        mlen = $urandom_range(1, 6);
        for (int k = 0; k < mlen; k++)
          send_item($urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT, 8'($urandom),
                    8'($urandom), 1'b0, pb);
        sent += mlen;
      end else begin
        send_item(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), pb);
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0]           perm [256];
    logic [7:0]           swap, pb;
    int                   j;
    logic [KEY_LEN_W-1:0] lengths [9];

    chk = new();
    lengths = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd257, 9'd5, 9'd0, 9'd2, 9'd100};
    lengths[6] = 9'($urandom_range(2, 255));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_key_length(9'd3);

    // Fill the whole table with a shuffle of 254 distinct bytes, leaving two
    // values out so that decrypt can miss, and write every password byte.
    // Nothing is ever read before it has been written.
    for (int i = 0; i < 256; i++) perm[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j       = $urandom_range(i);
      swap    = perm[i];
      perm[i] = perm[j];
      perm[j] = swap;
    end
    for (int i = 0; i < TABLE_SIZE; i++)
      send_item(FUNC_LOAD_TABLE, 8'(i), perm[i], 1'($urandom), pb);
    for (int i = 0; i < KEY_SLOTS; i++)
      send_item(FUNC_LOAD_KEY, 8'(i), 8'($urandom), 1'($urandom), pb);

    // Directed: password bytes 255 and 254 reduce to 1 and 0.
    send_item(FUNC_LOAD_KEY, 8'd0, 8'd255, 1'b0, pb);
    send_item(FUNC_LOAD_KEY, 8'd1, 8'd254, 1'b1, pb);
    send_item(FUNC_LOAD_KEY, 8'd2, 8'd0, 1'b0, pb);
    // Extreme data bytes on encrypt, with a wrap of the three-byte password.
    send_item(FUNC_ENCRYPT, 8'd0, 8'd0, 1'b1, pb);
    send_item(FUNC_ENCRYPT, 8'd255, 8'd255, 1'b0, pb);
    send_item(FUNC_ENCRYPT, 8'd17, 8'd254, 1'b0, pb);
    send_item(FUNC_ENCRYPT, 8'd0, 8'd253, 1'b0, pb);
    // Decrypt hits at the first and last table entry, then both absent bytes.
    send_item(FUNC_DECRYPT, 8'd0, perm[0], 1'b1, pb);
    send_item(FUNC_DECRYPT, 8'd255, perm[253], 1'b0, pb);
    send_item(FUNC_DECRYPT, 8'd0, perm[254], 1'b0, pb);
    send_item(FUNC_DECRYPT, 8'd0, perm[255], 1'b1, pb);
    // Table slots past the end write nothing but still restart the position.
    send_item(FUNC_ENCRYPT, 8'd0, 8'd1, 1'b1, pb);
    send_item(FUNC_LOAD_TABLE, 8'd254, 8'hff, 1'b0, pb);
    send_item(FUNC_ENCRYPT, 8'd0, 8'd1, 1'b0, pb);
    send_item(FUNC_LOAD_TABLE, 8'd255, 8'h00, 1'b1, pb);
    send_item(FUNC_DECRYPT, 8'd0, perm[10], 1'b0, pb);
    send_item(FUNC_LOAD_KEY, 8'd255, 8'haa, 1'b0, pb);

    // Stale position: leave it at 6 under a length of 8, then shrink to 2.
    wait_drained();
    set_key_length(9'd8);
    for (int k = 0; k < 6; k++) send_item(FUNC_ENCRYPT, 8'd0, plain_byte(), k == 0, pb);
    wait_drained();
    set_key_length(9'd2);
    send_item(FUNC_ENCRYPT, 8'd0, 8'd100, 1'b0, pb);
    send_item(FUNC_DECRYPT, 8'd0, perm[100], 1'b0, pb);

    // Random part in three idling phases, each run under three key lengths.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int b = 0; b < 3; b++) begin
        wait_drained();
        set_key_length(lengths[ph * 3 + b]);
        random_block(85);
      end
    end

    wait_drained();
    // The longest decrypt search plus the output register.
    repeat (300) @(posedge clk);
    if (chk.expected_beats.size() != 0)
      chk.report($sformatf("%0d results never arrived", chk.expected_beats.size()));

    $display("covered %0d input beats: %0d loads, %0d encrypts, %0d decrypts (%0d misses)",
             chk.beats_in, chk.loads, chk.encrypts, chk.decrypts, chk.misses);
    $display("checked %0d results under %0d key_length settings from 0 to 511",
             chk.beats_out, key_settings);
    if (chk.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[keyed_substitution_cipher_top.f]
rtl/ksc_pkg.sv
rtl/ksc_ram.sv
rtl/ksc_ctrl.sv
rtl/ksc_datapath.sv
rtl/keyed_substitution_cipher_top.sv
tb/sv/testbench.sv
